[rtl/core/rotation_matrix_to_quaternion_unit_assert.svh]
// Assertion macros shared by the rotation-to-quaternion checker
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
// Assert an implication on the rising clock, quiet while in reset
`define RMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert a next-cycle implication on the rising clock, quiet while in reset
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/core/rmq_pkg.sv]
// Package: sizes and branch codes for the rotation-to-quaternion unit
package rmq_pkg;
  localparam int DataWidthDef = 16;
  localparam int FracBitsDef  = 14;
  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2,
    SEL_W = 2'd3
  } sel_t;
endpackage

[rtl/core/rmq_div.sv]
// Pipelined signed divider: one quotient bit per stage, truncating toward zero
module rmq_div import rmq_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 24
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic        [DW-1:0] den,
  output logic signed [NW-1:0] quo
);
  // Numerator magnitude never exceeds 2^(NW-1), fits NW bits unsigned
  logic [NW-1:0] q_r   [NW+1];
  logic [DW:0]   rem_r [NW+1];
  logic [DW-1:0] den_r [NW+1];
  logic          neg_r [NW+1];
  logic [NW-1:0] mag;
  logic [DW+1:0] trial [NW];

  assign mag = num[NW-1] ? NW'(-num) : NW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0]   <= mag;
      rem_r[0] <= '0;
      den_r[0] <= den;
      neg_r[0] <= num[NW-1];
    end
  end

  // Restoring step per stage, MSB first
  for (genvar i = 0; i < NW; i++) begin : g_step
    logic [DW+1:0] sh;
    assign sh       = {rem_r[i], q_r[i][NW-1]};
    assign trial[i] = sh - {2'b00, den_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i+1] <= den_r[i];
        neg_r[i+1] <= neg_r[i];
        if (!trial[i][DW+1]) begin
          rem_r[i+1] <= trial[i][DW:0];
          q_r[i+1]   <= {q_r[i][NW-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= sh[DW:0];
          q_r[i+1]   <= {q_r[i][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = neg_r[NW] ? NW'(-q_r[NW]) : NW'(q_r[NW]);
endmodule

[rtl/core/rotation_matrix_to_quaternion_unit.sv]
// Rotation matrix to quaternion, fully pipelined
// Usage:
//   Input channel: nine matrix elements in_m00..in_m22 (signed, FRAC_BITS
//   fraction bits) with in_valid / in_stall. Output channel: out_qx..out_qw
//   and out_degenerate with out_valid / out_stall.
//   One beat is taken every cycle while out_stall is low; one result per beat.
//   Depth: input register, branch stage, a bit-per-stage square root, then a
//   bit-per-stage divider and the output register. Throughput: one beat per
//   cycle while the pipeline is not stalled.
//   Stall: out_stall with out_valid high freezes the whole pipeline, which also raises
//   in_stall; nothing is lost or repeated. The output register holds its beat.
//   Reset: rst_n low clears every valid bit; no beat is in flight after it.
//   The block holds no state between beats.
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_m00,
  input  logic signed [DATA_WIDTH-1:0] in_m01,
  input  logic signed [DATA_WIDTH-1:0] in_m02,
  input  logic signed [DATA_WIDTH-1:0] in_m10,
  input  logic signed [DATA_WIDTH-1:0] in_m11,
  input  logic signed [DATA_WIDTH-1:0] in_m12,
  input  logic signed [DATA_WIDTH-1:0] in_m20,
  input  logic signed [DATA_WIDTH-1:0] in_m21,
  input  logic signed [DATA_WIDTH-1:0] in_m22,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_qx,
  output logic signed [DATA_WIDTH-1:0] out_qy,
  output logic signed [DATA_WIDTH-1:0] out_qz,
  output logic signed [DATA_WIDTH-1:0] out_qw,
  output logic                         out_degenerate
);
  localparam int AW  = DATA_WIDTH + 3;            // root argument, signed
  localparam int RW  = AW + FRAC_BITS;            // radicand bits, unsigned
  localparam int RH  = (RW + 1) / 2;              // root width
  localparam int SQN = RH;                        // root stages
  localparam int DFW = DATA_WIDTH + 1;            // difference width
  localparam int NW  = DFW + FRAC_BITS + 1;       // dividend width
  localparam int DVW = RH + 1;                    // divisor width
  localparam int DLY = SQN + 1 + NW;              // span from s1 to div out
  localparam logic signed [AW-1:0] One = AW'(1) <<< FRAC_BITS;

  typedef logic signed [DATA_WIDTH-1:0] dat_t;
  typedef logic signed [DFW-1:0]        dif_t;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: register the beat
  logic v1_r;
  dat_t m_r [9];
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= in_m00; m_r[1] <= in_m01; m_r[2] <= in_m02;
      m_r[3] <= in_m10; m_r[4] <= in_m11; m_r[5] <= in_m12;
      m_r[6] <= in_m20; m_r[7] <= in_m21; m_r[8] <= in_m22;
    end
  end

  // Stage 2: pick the branch and form the root argument and the three numerators
  logic signed [AW-1:0] tr, arg_nxt;
  sel_t sel_nxt;
  dif_t d_w, d_x, d_y, d_z, dxy, dxz, dyz;
  assign tr  = AW'(m_r[0]) + AW'(m_r[4]) + AW'(m_r[8]);
  assign d_w = DFW'(m_r[7]) - DFW'(m_r[5]);
  assign d_x = DFW'(m_r[2]) - DFW'(m_r[6]);
  assign d_y = DFW'(m_r[3]) - DFW'(m_r[1]);
  assign dxy = DFW'(m_r[1]) + DFW'(m_r[3]);
  assign dxz = DFW'(m_r[2]) + DFW'(m_r[6]);
  assign dyz = DFW'(m_r[5]) + DFW'(m_r[7]);
  assign d_z = d_y;
  always_comb begin
    if (tr > 0) begin
      sel_nxt = SEL_W;
      arg_nxt = One + tr;
    end else if (m_r[0] > m_r[4] && m_r[0] > m_r[8]) begin
      sel_nxt = SEL_X;
      arg_nxt = One + AW'(m_r[0]) - AW'(m_r[4]) - AW'(m_r[8]);
    end else if (m_r[4] > m_r[8]) begin
      sel_nxt = SEL_Y;
      arg_nxt = One + AW'(m_r[4]) - AW'(m_r[0]) - AW'(m_r[8]);
    end else begin
      sel_nxt = SEL_Z;
      arg_nxt = One + AW'(m_r[8]) - AW'(m_r[0]) - AW'(m_r[4]);
    end
  end

  logic v2_r, deg2_r;
  sel_t sel2_r;
  logic [RW-1:0] rad2_r;
  dif_t n2_r [3];   // numerators in order for the three divided components
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sel2_r <= sel_nxt;
      deg2_r <= (arg_nxt <= 0);
      rad2_r <= (arg_nxt <= 0) ? '0 : (RW'(arg_nxt[AW-2:0]) << FRAC_BITS);
      // numerators: slot 0/1/2 carry the three non-root components (x,y,z,w order)
      case (sel_nxt)
        SEL_W:   begin n2_r[0] <= d_w; n2_r[1] <= d_x; n2_r[2] <= d_y; end
        SEL_X:   begin n2_r[0] <= dxy; n2_r[1] <= dxz; n2_r[2] <= d_w; end
        SEL_Y:   begin n2_r[0] <= dxy; n2_r[1] <= dyz; n2_r[2] <= d_x; end
        default: begin n2_r[0] <= dxz; n2_r[1] <= dyz; n2_r[2] <= d_z; end
      endcase
    end
  end

  // Square root: one result bit per stage, restoring
  logic [RW-1:0] sq_n  [SQN+1];
  logic [RH+1:0] sq_rem[SQN+1];
  logic [RH-1:0] sq_res[SQN+1];
  always_comb begin
    sq_n[0]   = rad2_r;
    sq_rem[0] = '0;
    sq_res[0] = '0;
  end
  localparam int RWP = 2 * RH;
  for (genvar k = 0; k < SQN; k++) begin : g_sq
    logic [RWP-1:0] np;
    logic [RH+1:0]  sh, tt;
    logic [RH+2:0]  df;
    logic [RW-1:0]  n_r;
    logic [RH+1:0]  rem_r;
    logic [RH-1:0]  res_r;
    assign np = RWP'(sq_n[k]);
    assign sh = {sq_rem[k][RH-1:0], np[RWP-1-2*k -: 2]};
    assign tt = {sq_res[k], 2'b01};
    assign df = {1'b0, sh} - {1'b0, tt};
    always_ff @(posedge clk) begin
      if (en) begin
        n_r <= sq_n[k];
        if (!df[RH+2]) begin
          rem_r <= df[RH+1:0];
          res_r <= {sq_res[k][RH-2:0], 1'b1};
        end else begin
          rem_r <= sh;
          res_r <= {sq_res[k][RH-2:0], 1'b0};
        end
      end
    end
    assign sq_n[k+1]   = n_r;
    assign sq_rem[k+1] = rem_r;
    assign sq_res[k+1] = res_r;
  end

  // Side pipe: carry control and numerators alongside the root
  logic v_p [SQN+1];
  logic deg_p [SQN+1];
  sel_t sel_p [SQN+1];
  dif_t n_p [SQN+1][3];
  always_comb begin
    v_p[0] = v2_r; deg_p[0] = deg2_r; sel_p[0] = sel2_r;
    n_p[0] = n2_r;
  end
  for (genvar k = 0; k < SQN; k++) begin : g_side
    logic vr, dr;
    sel_t sr;
    dif_t nr [3];
    always_ff @(posedge clk) begin
      if (!rst_n) vr <= 1'b0;
      else if (en) vr <= v_p[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dr <= deg_p[k]; sr <= sel_p[k]; nr <= n_p[k];
      end
    end
    assign v_p[k+1] = vr; assign deg_p[k+1] = dr;
    assign sel_p[k+1] = sr; assign n_p[k+1] = nr;
  end

  // After the root, combinationally: form dividends, divisor and the root-derived half
  logic [RH-1:0] s;
  logic [DVW-1:0] r4;
  assign s  = sq_res[SQN];
  assign r4 = (s == '0) ? DVW'(1) : {s, 1'b0};
  logic signed [NW-1:0] num_nxt [3];
  for (genvar j = 0; j < 3; j++) begin : g_num
    assign num_nxt[j] = NW'(n_p[SQN][j]) <<< FRAC_BITS;
  end

  logic signed [NW-1:0] quo [3];
  for (genvar j = 0; j < 3; j++) begin : g_div
    rmq_div #(.NW(NW), .DW(DVW)) u_div (
      .clk(clk), .en(en), .num(num_nxt[j]), .den(r4), .quo(quo[j])
    );
  end

  // Delay control and the half root to match the divider
  logic dv_p [NW+2];
  logic ddeg_p [NW+2];
  sel_t dsel_p [NW+2];
  logic [RH-1:0] dh_p [NW+2];
  always_comb begin
    dv_p[0] = v_p[SQN]; ddeg_p[0] = deg_p[SQN]; dsel_p[0] = sel_p[SQN];
    dh_p[0] = s >> 1;
  end
  for (genvar k = 0; k < NW + 1; k++) begin : g_dly
    logic vr, dr;
    sel_t sr;
    logic [RH-1:0] hr;
    always_ff @(posedge clk) begin
      if (!rst_n) vr <= 1'b0;
      else if (en) vr <= dv_p[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dr <= ddeg_p[k]; sr <= dsel_p[k]; hr <= dh_p[k];
      end
    end
    assign dv_p[k+1] = vr; assign ddeg_p[k+1] = dr;
    assign dsel_p[k+1] = sr; assign dh_p[k+1] = hr;
  end

  // Saturate to the output format
  function automatic dat_t sat(input logic signed [NW-1:0] v);
    logic signed [NW-1:0] hi, lo;
    hi = NW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    lo = -hi - NW'(1);
    if (v > hi) sat = dat_t'(hi);
    else if (v < lo) sat = dat_t'(lo);
    else sat = dat_t'(v);
  endfunction

  dat_t sq0, sq1, sq2, sh_half;
  assign sq0 = sat(quo[0]);
  assign sq1 = sat(quo[1]);
  assign sq2 = sat(quo[2]);
  assign sh_half = sat(NW'(dh_p[NW+1]));

  // Output register: route the three quotients and the half root, or zeros when degenerate
  logic v_o_r, deg_o_r;
  dat_t qx_r, qy_r, qz_r, qw_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_o_r <= 1'b0;
    else if (en) v_o_r <= dv_p[NW+1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      deg_o_r <= ddeg_p[NW+1];
      if (ddeg_p[NW+1]) begin
        qx_r <= '0; qy_r <= '0; qz_r <= '0; qw_r <= '0;
      end else begin
        case (dsel_p[NW+1])
          SEL_W:   begin qx_r <= sq0; qy_r <= sq1; qz_r <= sq2; qw_r <= sh_half; end
          SEL_X:   begin qx_r <= sh_half; qy_r <= sq0; qz_r <= sq1; qw_r <= sq2; end
          SEL_Y:   begin qx_r <= sq0; qy_r <= sh_half; qz_r <= sq1; qw_r <= sq2; end
          default: begin qx_r <= sq0; qy_r <= sq1; qz_r <= sh_half; qw_r <= sq2; end
        endcase
      end
    end
  end

  assign out_valid      = v_o_r;
  assign out_degenerate = deg_o_r;
  assign out_qx = qx_r;
  assign out_qy = qy_r;
  assign out_qz = qz_r;
  assign out_qw = qw_r;
endmodule

[rtl/core/rmq_checker.sv]
// Port-level checker for the rotation-to-quaternion unit, with its bind
`include "rotation_matrix_to_quaternion_unit_assert.svh"
module rmq_checker import rmq_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [DATA_WIDTH-1:0] out_qx,
  input logic [DATA_WIDTH-1:0] out_qy,
  input logic [DATA_WIDTH-1:0] out_qz,
  input logic [DATA_WIDTH-1:0] out_qw,
  input logic                  out_degenerate
);
  // Backpressure reaches the input exactly when a held beat is stalled
  `RMQ_ASSERT_IMPL(a_stall_prop, clk, rst_n, out_valid && out_stall, in_stall)
  `RMQ_ASSERT_IMPL(a_no_false_stall, clk, rst_n, !(out_valid && out_stall), !in_stall)
  // A degenerate beat carries all-zero components
  `RMQ_ASSERT_IMPL(a_deg_zero, clk, rst_n, out_valid && out_degenerate,
    out_qx == '0 && out_qy == '0 && out_qz == '0 && out_qw == '0)
  // A stalled beat stays valid and keeps its out_qx and out_qw
  `RMQ_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_qx) && $stable(out_qw))
endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rmq_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_qx(out_qx), .out_qy(out_qy), .out_qz(out_qz),
  .out_qw(out_qw), .out_degenerate(out_degenerate)
);
